// File: hdl/mpc_pkg.sv
// shared types and constants for the midpoint subdivision line clipper
// no dependencies
`default_nettype none

package mpc_pkg;

	// configuration port address width: four 32-bit registers
	localparam int ADDR_BITS = 4;

	// register indexes
	localparam logic [1:0] REG_X_MIN = 2'd0;
	localparam logic [1:0] REG_X_MAX = 2'd1;
	localparam logic [1:0] REG_Y_MIN = 2'd2;
	localparam logic [1:0] REG_Y_MAX = 2'd3;

	// outcode bits
	localparam logic [3:0] OC_LEFT  = 4'b0001;
	localparam logic [3:0] OC_RIGHT = 4'b0010;
	localparam logic [3:0] OC_BELOW = 4'b0100;
	localparam logic [3:0] OC_ABOVE = 4'b1000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EVAL,
		ST_PUSH2,
		ST_DONE,
		ST_RD,
		ST_LOAD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic seg_ready;
		logic seg_load;
		logic pop;
		logic emit;
		logic push_lo;
		logic push_hi;
		logic res_read;
		logic res_load;
		logic empty_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic queue_empty;
		logic all_in;
		logic drop;
		logic none_emitted;
		logic drain_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// File: hdl/mpc_ifs.sv
// handshake channels: input segment and result piece
// no dependencies
`default_nettype none

interface mpc_seg_if #(
	parameter int COORD_BITS = 12
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface mpc_res_if #(
	parameter int COORD_BITS = 12
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] piece_start_x;
	logic signed [COORD_BITS-1:0] piece_start_y;
	logic signed [COORD_BITS-1:0] piece_end_x;
	logic signed [COORD_BITS-1:0] piece_end_y;
	logic                         visible;
	logic                         overflow;
	logic                         last;

	modport source (output valid, piece_start_x, piece_start_y, piece_end_x, piece_end_y,
		visible, overflow, last, input ready);
	modport sink (input valid, piece_start_x, piece_start_y, piece_end_x, piece_end_y,
		visible, overflow, last, output ready);
endinterface

`default_nettype wire

// File: hdl/midpoint_subdivision_line_clipper.sv
// top level of the midpoint subdivision line clipper
// depends on mpc_pkg, mpc_ifs, mpc_cfg, mpc_ctrl, mpc_dp
//
//   port       role       carries
//   seg_in     sink       one segment: start_x, start_y, end_x, end_y
//   res_out    source     one piece: piece_* coordinates, visible, overflow, last
//   psel..     apb slave  window_x_min, window_x_max, window_y_min, window_y_max
//
// one segment is worked at a time; seg_in.ready is high only while idle
// each queued piece is fetched and classified, and when split its second half
// is pushed in a state of its own, bound by the single write port of the piece
// queue; buffered results are then read from the result buffer and loaded into
// the output register one by one, and the drain waits while res_out is stalled
// a stalled res_out holds the result in its register; the next segment is
// taken while the final result of the last one still waits there
// arst_n clears the sequencer, counters and output valid; the window resets
// to -512..511 in both axes; queue and result buffer need no clearing
`default_nettype none

module midpoint_subdivision_line_clipper
	import mpc_pkg::*;
#(
	parameter int COORD_BITS  = 12,
	parameter int QUEUE_DEPTH = 32,
	parameter int MAX_PIECES  = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	mpc_seg_if.sink                   seg_in,
	mpc_res_if.source                 res_out
);

	// window edges; the user must write them only while idle, the block does not enforce it
	logic signed [COORD_BITS-1:0] win_x_min, win_x_max, win_y_min, win_y_max;

	// sequencer commands and datapath status
	cmd_t    cmd;
	status_t status;

	mpc_cfg #(
		.COORD_BITS(COORD_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.win_x_min (win_x_min),
		.win_x_max (win_x_max),
		.win_y_min (win_y_min),
		.win_y_max (win_y_max)
	);

	// fetch / classify / split loop, then drain of the result buffer
	mpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_in.valid),
		.status    (status),
		.cmd       (cmd)
	);

	assign seg_in.ready = cmd.seg_ready;

	// results are held back until the segment is finished, since overflow
	// is only known then and rides on every result of the segment
	mpc_dp #(
		.COORD_BITS  (COORD_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_PIECES  (MAX_PIECES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.win_x_min    (win_x_min),
		.win_x_max    (win_x_max),
		.win_y_min    (win_y_min),
		.win_y_max    (win_y_max),
		.seg_start_x  (seg_in.start_x),
		.seg_start_y  (seg_in.start_y),
		.seg_end_x    (seg_in.end_x),
		.seg_end_y    (seg_in.end_y),
		.res_ready    (res_out.ready),
		.res_valid    (res_out.valid),
		.res_start_x  (res_out.piece_start_x),
		.res_start_y  (res_out.piece_start_y),
		.res_end_x    (res_out.piece_end_x),
		.res_end_y    (res_out.piece_end_y),
		.res_visible  (res_out.visible),
		.res_overflow (res_out.overflow),
		.res_last     (res_out.last)
	);

endmodule

`default_nettype wire

// File: hdl/mpc_cfg.sv
// window registers behind the apb-style configuration port
// depends on mpc_pkg
`default_nettype none

module mpc_cfg
	import mpc_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ADDR_BITS-1:0]         paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	output logic signed [COORD_BITS-1:0]      win_x_min,
	output logic signed [COORD_BITS-1:0]      win_x_max,
	output logic signed [COORD_BITS-1:0]      win_y_min,
	output logic signed [COORD_BITS-1:0]      win_y_max
);

	// narrow coordinates clamp the default window to the full range
	localparam int WinLo = (COORD_BITS > 10) ? -512 : -(1 << (COORD_BITS - 1));
	localparam int WinHi = (COORD_BITS > 10) ? 511 : (1 << (COORD_BITS - 1)) - 1;
	localparam logic signed [COORD_BITS-1:0] WinLoRst = COORD_BITS'(WinLo);
	localparam logic signed [COORD_BITS-1:0] WinHiRst = COORD_BITS'(WinHi);

	logic signed [COORD_BITS-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic                         wr_en;
	logic [1:0]                   reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= WinLoRst;
			x_max_q <= WinHiRst;
			y_min_q <= WinLoRst;
			y_max_q <= WinHiRst;
		end else if (wr_en) begin
			case (reg_idx)
				REG_X_MIN: x_min_q <= pwdata[COORD_BITS-1:0];
				REG_X_MAX: x_max_q <= pwdata[COORD_BITS-1:0];
				REG_Y_MIN: y_min_q <= pwdata[COORD_BITS-1:0];
				REG_Y_MAX: y_max_q <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_X_MIN: prdata = 32'(x_min_q);
			REG_X_MAX: prdata = 32'(x_max_q);
			REG_Y_MIN: prdata = 32'(y_min_q);
			REG_Y_MAX: prdata = 32'(y_max_q);
			default:   prdata = '0;
		endcase
	end

	assign win_x_min = x_min_q;
	assign win_x_max = x_max_q;
	assign win_y_min = y_min_q;
	assign win_y_max = y_max_q;

endmodule

`default_nettype wire

// File: hdl/mpc_ctrl.sv
// sequencer: piece loop over the queue, then drain of buffered results
// depends on mpc_pkg
`default_nettype none

module mpc_ctrl
	import mpc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    seg_valid,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (seg_valid) state_nx = ST_FETCH;
			end
			ST_FETCH: state_nx = ST_EVAL;
			ST_EVAL: begin
				if (status.all_in || status.drop) begin
					state_nx = status.queue_empty ? ST_DONE : ST_FETCH;
				end else begin
					state_nx = ST_PUSH2;
				end
			end
			// the first half always fits, so the queue is never empty here
			ST_PUSH2: state_nx = ST_FETCH;
			ST_DONE: begin
				if (!status.none_emitted) begin
					state_nx = ST_RD;
				end else if (status.out_free) begin
					state_nx = ST_IDLE;
				end
			end
			ST_RD: state_nx = ST_LOAD;
			ST_LOAD: begin
				if (status.out_free) state_nx = status.drain_last ? ST_IDLE : ST_RD;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.seg_ready = 1'b1;
				cmd.seg_load  = seg_valid;
			end
			ST_FETCH: cmd.pop = 1'b1;
			ST_EVAL: begin
				cmd.emit    = status.all_in;
				cmd.push_lo = !status.all_in && !status.drop;
			end
			ST_PUSH2: cmd.push_hi = 1'b1;
			ST_DONE:  cmd.empty_load = status.none_emitted && status.out_free;
			ST_RD:    cmd.res_read = 1'b1;
			ST_LOAD:  cmd.res_load = status.out_free;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/mpc_dp.sv
// datapath: piece queue, classification, midpoint split, result buffer, output register
// depends on mpc_pkg
`default_nettype none

module mpc_dp
	import mpc_pkg::*;
#(
	parameter int COORD_BITS  = 12,
	parameter int QUEUE_DEPTH = 32,
	parameter int MAX_PIECES  = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cmd_t                          cmd,
	output status_t                            status,
	input  wire logic signed [COORD_BITS-1:0]  win_x_min,
	input  wire logic signed [COORD_BITS-1:0]  win_x_max,
	input  wire logic signed [COORD_BITS-1:0]  win_y_min,
	input  wire logic signed [COORD_BITS-1:0]  win_y_max,
	input  wire logic signed [COORD_BITS-1:0]  seg_start_x,
	input  wire logic signed [COORD_BITS-1:0]  seg_start_y,
	input  wire logic signed [COORD_BITS-1:0]  seg_end_x,
	input  wire logic signed [COORD_BITS-1:0]  seg_end_y,
	input  wire logic                          res_ready,
	output logic                               res_valid,
	output logic signed [COORD_BITS-1:0]       res_start_x,
	output logic signed [COORD_BITS-1:0]       res_start_y,
	output logic signed [COORD_BITS-1:0]       res_end_x,
	output logic signed [COORD_BITS-1:0]       res_end_y,
	output logic                               res_visible,
	output logic                               res_overflow,
	output logic                               res_last
);

	localparam int C   = COORD_BITS;
	localparam int PW  = 4 * COORD_BITS;
	localparam int QIW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int RIW = $clog2(MAX_PIECES);
	localparam int ECW = $clog2(MAX_PIECES + 1);
	localparam logic [QIW-1:0] QLast = QIW'(QUEUE_DEPTH - 1);
	localparam logic [QCW-1:0] QFull = QCW'(QUEUE_DEPTH);
	localparam logic [ECW-1:0] ECap  = ECW'(MAX_PIECES);

	function automatic logic [3:0] outcode(
		input logic signed [C-1:0] x,
		input logic signed [C-1:0] y,
		input logic signed [C-1:0] xl,
		input logic signed [C-1:0] xh,
		input logic signed [C-1:0] yl,
		input logic signed [C-1:0] yh
	);
		logic [3:0] c;
		c = '0;
		if (x < xl) c = c | OC_LEFT;
		if (x > xh) c = c | OC_RIGHT;
		if (y < yl) c = c | OC_BELOW;
		if (y > yh) c = c | OC_ABOVE;
		return c;
	endfunction

	// piece queue
	logic [PW-1:0]  q_mem [QUEUE_DEPTH];
	logic [PW-1:0]  q_rd_q;
	logic [QIW-1:0] head_q, tail_q;
	logic [QCW-1:0] count_q;
	logic           push, push_ok, q_we;
	logic [QIW-1:0] q_waddr;
	logic [PW-1:0]  q_wdata;

	// result buffer
	logic [PW-1:0]  r_mem [MAX_PIECES];
	logic [PW-1:0]  r_rd_q;
	logic [ECW-1:0] emitted_q;
	logic [RIW-1:0] r_idx_q;
	logic           cap_full, r_we;
	logic           ovf_q;

	// current piece
	logic signed [C-1:0] ax, ay, bx, by, mx, my;
	logic signed [C:0]   dx, dy, sx, sy;
	logic [3:0]          c1, c2;
	logic                tiny;

	logic out_valid_q, out_free, drain_last;

	assign ax = q_rd_q[PW-1 -: C];
	assign ay = q_rd_q[PW-C-1 -: C];
	assign bx = q_rd_q[PW-2*C-1 -: C];
	assign by = q_rd_q[C-1:0];

	assign c1 = outcode(ax, ay, win_x_min, win_x_max, win_y_min, win_y_max);
	assign c2 = outcode(bx, by, win_x_min, win_x_max, win_y_min, win_y_max);

	assign dx = {ax[C-1], ax} - {bx[C-1], bx};
	assign dy = {ay[C-1], ay} - {by[C-1], by};
	assign sx = {ax[C-1], ax} + {bx[C-1], bx};
	assign sy = {ay[C-1], ay} + {by[C-1], by};
	// floor of the halved sum
	assign mx = sx[C:1];
	assign my = sy[C:1];
	assign tiny = (dx == '0 || dx == (C+1)'(1) || dx == '1) &&
		(dy == '0 || dy == (C+1)'(1) || dy == '1);

	assign push    = cmd.push_lo || cmd.push_hi;
	assign push_ok = count_q != QFull;
	assign q_we    = cmd.seg_load || (push && push_ok);
	assign q_waddr = cmd.seg_load ? '0 : tail_q;

	always_comb begin
		if (cmd.seg_load) begin
			q_wdata = {seg_start_x, seg_start_y, seg_end_x, seg_end_y};
		end else if (cmd.push_lo) begin
			q_wdata = {ax, ay, mx, my};
		end else begin
			q_wdata = {mx, my, bx, by};
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) q_mem[q_waddr] <= q_wdata;
		if (cmd.pop) q_rd_q <= q_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.seg_load) begin
			head_q  <= '0;
			tail_q  <= QIW'(1);
			count_q <= QCW'(1);
		end else begin
			if (cmd.pop) begin
				head_q  <= (head_q == QLast) ? '0 : head_q + QIW'(1);
				count_q <= count_q - QCW'(1);
			end else if (push && push_ok) begin
				tail_q  <= (tail_q == QLast) ? '0 : tail_q + QIW'(1);
				count_q <= count_q + QCW'(1);
			end
		end
	end

	assign cap_full = emitted_q == ECap;
	assign r_we     = cmd.emit && !cap_full;

	always_ff @(posedge clk) begin
		if (r_we) r_mem[emitted_q[RIW-1:0]] <= q_rd_q;
		if (cmd.res_read) r_rd_q <= r_mem[r_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitted_q <= '0;
			r_idx_q   <= '0;
			ovf_q     <= 1'b0;
		end else if (cmd.seg_load) begin
			emitted_q <= '0;
			r_idx_q   <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (r_we) emitted_q <= emitted_q + ECW'(1);
			if (cmd.res_load) r_idx_q <= r_idx_q + RIW'(1);
			if ((cmd.emit && cap_full) || (push && !push_ok)) ovf_q <= 1'b1;
		end
	end

	assign drain_last = (ECW'(r_idx_q) + ECW'(1)) == emitted_q;
	assign out_free   = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load || cmd.empty_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			{res_start_x, res_start_y, res_end_x, res_end_y} <= r_rd_q;
			res_visible  <= 1'b1;
			res_overflow <= ovf_q;
			res_last     <= drain_last;
		end else if (cmd.empty_load) begin
			{res_start_x, res_start_y, res_end_x, res_end_y} <= '0;
			res_visible  <= 1'b0;
			res_overflow <= ovf_q;
			res_last     <= 1'b1;
		end
	end

	assign res_valid = out_valid_q;

	assign status.queue_empty  = count_q == '0;
	assign status.all_in       = (c1 == '0) && (c2 == '0);
	assign status.drop         = ((c1 & c2) != '0) || tiny;
	assign status.none_emitted = emitted_q == '0;
	assign status.drain_last   = drain_last;
	assign status.out_free     = out_free;

endmodule

`default_nettype wire

// File: hdl/mpc_checker.sv
// port-level assertions for the midpoint subdivision line clipper, with bind
// depends on midpoint_subdivision_line_clipper
`default_nettype none

module mpc_checker #(
	parameter int COORD_BITS = 12
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [COORD_BITS-1:0] sx,
	input wire logic [COORD_BITS-1:0] sy,
	input wire logic [COORD_BITS-1:0] ex,
	input wire logic [COORD_BITS-1:0] ey,
	input wire logic                  visible,
	input wire logic                  overflow,
	input wire logic                  last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({sx, sy, ex, ey, visible, overflow, last}))
		else $error("result changed while stalled");

	a_hidden_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> last)
		else $error("rejected segment result not marked last");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> (sx == '0 && sy == '0 && ex == '0 && ey == '0))
		else $error("rejected segment result carries coordinates");

	a_one_segment: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second segment taken while one is in work");

endmodule

bind midpoint_subdivision_line_clipper mpc_checker #(
	.COORD_BITS(COORD_BITS)
) u_mpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (seg_in.valid),
	.in_ready  (seg_in.ready),
	.out_valid (res_out.valid),
	.out_ready (res_out.ready),
	.sx        (res_out.piece_start_x),
	.sy        (res_out.piece_start_y),
	.ex        (res_out.piece_end_x),
	.ey        (res_out.piece_end_y),
	.visible   (res_out.visible),
	.overflow  (res_out.overflow),
	.last      (res_out.last)
);

`default_nettype wire

// File: tb/mpc_clip_checker.sv
`timescale 1ns / 1ps
// result checker for the midpoint subdivision line clipper: follows apb writes,
// predicts the clipped pieces of every accepted segment and compares results
// depends on mpc_pkg and mpc_ifs
module mpc_clip_checker
	import mpc_pkg::*;
#(
	parameter int COORD_BITS  = 12,
	parameter int QUEUE_DEPTH = 32,
	parameter int MAX_PIECES  = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	mpc_seg_if                   seg,
	mpc_res_if                   res,
	output int                   fail_count,
	output int                   owed,
	output int                   segs_taken,
	output int                   pieces_seen,
	output int                   blanks_seen
);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t ax, ay, bx, by;
	} span_t;

	typedef struct {
		coord_t ax, ay, bx, by;
		logic   visible, overflow, last;
	} piece_res_t;

	coord_t     x_lo, x_hi, y_lo, y_hi;
	piece_res_t owed_pieces[$];

	initial begin
		fail_count  = 0;
		owed        = 0;
		segs_taken  = 0;
		pieces_seen = 0;
		blanks_seen = 0;
	end

	// shadow of the window registers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lo <= -512;
			x_hi <= 511;
			y_lo <= -512;
			y_hi <= 511;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[ADDR_BITS-1:2])
				REG_X_MIN: x_lo <= pwdata[COORD_BITS-1:0];
				REG_X_MAX: x_hi <= pwdata[COORD_BITS-1:0];
				REG_Y_MIN: y_lo <= pwdata[COORD_BITS-1:0];
				REG_Y_MAX: y_hi <= pwdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [3:0] zone_code(coord_t x, coord_t y);
		logic [3:0] c;
		c = '0;
		if (x < x_lo) c |= OC_LEFT;
		if (x > x_hi) c |= OC_RIGHT;
		if (y < y_lo) c |= OC_BELOW;
		if (y > y_hi) c |= OC_ABOVE;
		return c;
	endfunction

	function automatic coord_t floor_mid(coord_t a, coord_t b);
		int s;
		s = int'(a) + int'(b);
		return coord_t'(s >>> 1);
	endfunction

	function automatic bit is_tiny(span_t p);
		int dx, dy;
		dx = int'(p.ax) - int'(p.bx);
		dy = int'(p.ay) - int'(p.by);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return dx <= 1 && dy <= 1;
	endfunction

	// breadth-first subdivision of one segment; appends its results to owed_pieces
	function automatic void clip_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
		span_t      ring[QUEUE_DEPTH];
		span_t      p, half;
		piece_res_t found[$];
		piece_res_t r;
		int         head, count;
		logic       spill;
		logic [3:0] c1, c2;
		coord_t     mx, my;
		head  = 0;
		count = 1;
		spill = 1'b0;
		ring[0] = span_t'{sx, sy, ex, ey};
		while (count > 0) begin
			p     = ring[head];
			head  = (head + 1) % QUEUE_DEPTH;
			count = count - 1;
			c1    = zone_code(p.ax, p.ay);
			c2    = zone_code(p.bx, p.by);
			if (c1 == 0 && c2 == 0) begin
				if (found.size() < MAX_PIECES)
					found.push_back(piece_res_t'{p.ax, p.ay, p.bx, p.by, 1'b1, 1'b0, 1'b0});
				else
					spill = 1'b1;
			end else if ((c1 & c2) == 0 && !is_tiny(p)) begin
				mx = floor_mid(p.ax, p.bx);
				my = floor_mid(p.ay, p.by);
				for (int h = 0; h < 2; h++) begin
					if (h == 0)
						half = span_t'{p.ax, p.ay, mx, my};
					else
						half = span_t'{mx, my, p.bx, p.by};
					if (count >= QUEUE_DEPTH) begin
						spill = 1'b1;
					end else begin
						ring[(head + count) % QUEUE_DEPTH] = half;
						count = count + 1;
					end
				end
			end
		end
		if (found.size() == 0)
			found.push_back(piece_res_t'{'0, '0, '0, '0, 1'b0, 1'b0, 1'b0});
		foreach (found[k]) begin
			r          = found[k];
			r.overflow = spill;
			r.last     = (k == found.size() - 1);
			owed_pieces.push_back(r);
		end
	endfunction

	task automatic note_fault(input string what);
		fail_count++;
		if (fail_count <= 100)
			$display("%0t ns: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic signed [31:0] got,
			input logic signed [31:0] want);
		if (got !== want)
			note_fault($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	always @(posedge clk) begin
		piece_res_t want;
		if (arst_n) begin
			// a result leaving at the edge a new segment enters belongs to the older one
			if (res.valid && res.ready) begin
				if (owed_pieces.size() == 0) begin
					note_fault("result arrived with no piece outstanding");
				end else begin
					want = owed_pieces.pop_front();
					check_field("piece_start_x", res.piece_start_x, want.ax);
					check_field("piece_start_y", res.piece_start_y, want.ay);
					check_field("piece_end_x", res.piece_end_x, want.bx);
					check_field("piece_end_y", res.piece_end_y, want.by);
					check_field("visible", res.visible, want.visible);
					check_field("overflow", res.overflow, want.overflow);
					check_field("last", res.last, want.last);
					if (want.visible)
						pieces_seen++;
					else
						blanks_seen++;
				end
			end
			if (seg.valid && seg.ready) begin
				clip_segment(seg.start_x, seg.start_y, seg.end_x, seg.end_y);
				segs_taken++;
			end
			owed = owed_pieces.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// top of the line clipper testbench: clock, reset, apb window writes, segment
// stimulus and result back-pressure; checking lives in mpc_clip_checker
// depends on mpc_pkg, mpc_ifs, midpoint_subdivision_line_clipper, mpc_clip_checker
module tb;
	import mpc_pkg::*;

	localparam int COORD_BITS  = 12;
	localparam int QUEUE_DEPTH = 32;
	localparam int MAX_PIECES  = 64;
	// extremes of a coordinate
	localparam int C_MIN = -(1 << (COORD_BITS - 1));
	localparam int C_MAX = (1 << (COORD_BITS - 1)) - 1;
	// watchdog bound on the whole run: cycles counts from time zero and never restarts
	localparam int LIMIT = 2_000_000;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	logic                 clk     = 1'b0;
	logic                 arst_n  = 1'b0;
	logic                 psel    = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite  = 1'b0;
	logic [ADDR_BITS-1:0] paddr   = '0;
	logic [31:0]          pwdata  = '0;
	logic [31:0]          prdata;
	logic                 pready;

	// result back-pressure and the no-idling stretch
	logic take_ready = 1'b0;
	logic calm       = 1'b0;

	int fail_count, owed, segs_taken, pieces_seen, blanks_seen;
	int cycles   = 0;
	int settings = 1;

	// window as last written, used to steer segments toward its edges
	int win_x_lo = -512;
	int win_x_hi = 511;
	int win_y_lo = -512;
	int win_y_hi = 511;

	mpc_seg_if #(.COORD_BITS(COORD_BITS)) seg_ch ();
	mpc_res_if #(.COORD_BITS(COORD_BITS)) res_ch ();

	assign res_ch.ready = take_ready;

	midpoint_subdivision_line_clipper #(
		.COORD_BITS (COORD_BITS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.MAX_PIECES (MAX_PIECES)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.seg_in (seg_ch),
		.res_out(res_ch)
	);

	mpc_clip_checker #(
		.COORD_BITS (COORD_BITS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.MAX_PIECES (MAX_PIECES)
	) clip_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.seg        (seg_ch),
		.res        (res_ch),
		.fail_count (fail_count),
		.owed       (owed),
		.segs_taken (segs_taken),
		.pieces_seen(pieces_seen),
		.blanks_seen(blanks_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// the receiver drops ready with a chance of 11 in a hundred, except in the calm stretch
	always @(posedge clk) begin
		if (!arst_n)
			take_ready <= 1'b0;
		else
			take_ready <= calm || ($urandom_range(99, 0) >= 11);
	end

	// one apb write: setup phase, then access until pready, then idle,
	// so that psel never drops and rises in the same step
	task automatic write_reg(input logic [1:0] idx, input int value);
		logic [31:0] data;
		data = $urandom();
		// upper bits are junk on purpose, only the low coordinate bits count
		data[COORD_BITS-1:0] = value[COORD_BITS-1:0];
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// wait until every owed result is back, then let the sequencer
	// settle in idle before the window changes
	task automatic drain();
		seg_ch.valid <= 1'b0;
		do @(negedge clk); while (owed != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_window(input int xl, input int xh, input int yl, input int yh);
		drain();
		write_reg(REG_X_MIN, xl);
		write_reg(REG_X_MAX, xh);
		write_reg(REG_Y_MIN, yl);
		write_reg(REG_Y_MAX, yh);
		win_x_lo = xl;
		win_x_hi = xh;
		win_y_lo = yl;
		win_y_hi = yh;
		settings++;
	endtask

	// offer one segment, with random idle cycles ahead of it, and hold it until taken
	task automatic send_segment(input coord_t sx, input coord_t sy, input coord_t ex,
			input coord_t ey);
		while (!calm && $urandom_range(99, 0) < 11) begin
			// payload wanders while valid is low
			seg_ch.valid   <= 1'b0;
			seg_ch.start_x <= coord_t'($urandom());
			seg_ch.end_y   <= coord_t'($urandom());
			@(posedge clk);
		end
		seg_ch.valid   <= 1'b1;
		seg_ch.start_x <= sx;
		seg_ch.start_y <= sy;
		seg_ch.end_x   <= ex;
		seg_ch.end_y   <= ey;
		do @(posedge clk); while (!seg_ch.ready);
	endtask

	// a coordinate somewhere in [lo - margin, hi + margin], kept inside the field range
	function automatic coord_t near(input int lo, input int hi, input int margin);
		int a, b, off;
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		a = a - margin;
		b = b + margin;
		if (a < C_MIN) a = C_MIN;
		if (b > C_MAX) b = C_MAX;
		off = $urandom_range(b - a, 0);
		return coord_t'(a + off);
	endfunction

	function automatic coord_t rim_value();
		case ($urandom_range(3, 0))
			0: return coord_t'(C_MIN);
			1: return coord_t'(C_MAX);
			2: return coord_t'(0);
			default: return coord_t'(-1);
		endcase
	endfunction

	// mostly segments that cross or hug the window, so that subdivision goes deep;
	// the rest is uniform noise and field extremes
	task automatic send_random();
		int     style, ex0, ey0;
		coord_t sx, sy, ex, ey;
		style = $urandom_range(99, 0);
		if (style < 45) begin
			// one end inside, the other often far out
			sx = near(win_x_lo, win_x_hi, 0);
			sy = near(win_y_lo, win_y_hi, 0);
			ex = near(win_x_lo, win_x_hi, 700);
			ey = near(win_y_lo, win_y_hi, 700);
		end else if (style < 65) begin
			sx = near(win_x_lo, win_x_hi, 40);
			sy = near(win_y_lo, win_y_hi, 40);
			ex = near(win_x_lo, win_x_hi, 40);
			ey = near(win_y_lo, win_y_hi, 40);
		end else if (style < 75) begin
			// short pieces around a corner of the window: tiny straddles
			ex0 = $urandom_range(1, 0) ? win_x_lo : win_x_hi;
			ey0 = $urandom_range(1, 0) ? win_y_lo : win_y_hi;
			sx = near(ex0, ex0, 2);
			sy = near(ey0, ey0, 2);
			ex = near(ex0, ex0, 2);
			ey = near(ey0, ey0, 2);
		end else if (style < 90) begin
			sx = coord_t'($urandom());
			sy = coord_t'($urandom());
			ex = coord_t'($urandom());
			ey = coord_t'($urandom());
		end else begin
			sx = rim_value();
			sy = rim_value();
			ex = rim_value();
			ey = rim_value();
		end
		if ($urandom_range(1, 0))
			send_segment(ex, ey, sx, sy);
		else
			send_segment(sx, sy, ex, ey);
	endtask

	task automatic send_randoms(input int count);
		repeat (count) send_random();
	endtask

	initial begin
		seg_ch.valid   = 1'b0;
		seg_ch.start_x = '0;
		seg_ch.start_y = '0;
		seg_ch.end_x   = '0;
		seg_ch.end_y   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed segments against the reset window -512..511
		send_segment(0, 0, 100, -50);             // wholly inside
		send_segment(5, 5, 5, 5);                 // single point inside
		send_segment(600, 0, 600, 0);             // single point outside
		send_segment(-1000, 0, -600, 100);        // left of the window
		send_segment(600, -10, 900, 10);          // right
		send_segment(0, -600, 10, C_MIN);         // below
		send_segment(0, 600, -5, C_MAX);          // above
		send_segment(C_MIN, C_MIN, C_MAX, C_MAX); // full diagonal
		send_segment(C_MAX, C_MIN, C_MIN, C_MAX); // other diagonal
		send_segment(C_MIN, 0, C_MAX, 0);         // crosses the window from left to right
		send_segment(0, C_MAX, 0, C_MIN);         // crosses the window from top to bottom
		send_segment(0, 0, C_MAX, 100);           // leaves through the right edge
		send_segment(511, 0, 512, 0);             // tiny straddle, dropped
		send_segment(511, 511, 512, 512);         // tiny straddle on the corner
		send_segment(-600, 500, -500, 600);       // passes the corner outside
		send_segment(-600, 400, -400, 600);       // clips the corner
		send_segment(-513, -3, 0, 0);             // odd negative sums: floor midpoint
		send_segment(-512, -512, 511, 511);       // exactly on the edges
		send_segment(-513, -513, 512, 512);       // one step outside both corners
		send_segment(0, 0, 0, 0);
		send_segment(-1, -1, C_MAX, C_MIN);
		send_segment(C_MIN, C_MIN, C_MIN, C_MAX); // along the far left rim
		send_randoms(40);

		// window covering the whole field: nothing is ever clipped
		set_window(C_MIN, C_MAX, C_MIN, C_MAX);
		send_randoms(50);

		// small window, with both sides running flat out
		set_window(-20, 20, -10, 10);
		calm <= 1'b1;
		send_randoms(60);
		calm <= 1'b0;

		// inverted x range: every point fails one x test
		set_window(100, -100, -300, 300);
		send_randoms(40);

		// window shrunk to a vertical line
		set_window(0, 0, C_MIN, C_MAX);
		send_randoms(40);

		// window hugging the bottom-right extremes
		set_window(2000, C_MAX, C_MIN, -2000);
		send_randoms(40);

		// a few random windows, ordered edges
		repeat (3) begin
			int xa, xb, ya, yb;
			xa = near(C_MIN, C_MAX, 0);
			xb = near(C_MIN, C_MAX, 0);
			ya = near(C_MIN, C_MAX, 0);
			yb = near(C_MIN, C_MAX, 0);
			set_window(xa < xb ? xa : xb, xa < xb ? xb : xa,
				ya < yb ? ya : yb, ya < yb ? yb : ya);
			send_randoms(33);
		end

		// back to the reset window through the port
		set_window(-512, 511, -512, 511);
		send_randoms(40);

		drain();
		repeat (20) @(posedge clk);
		$display("%0d segments over %0d window settings; %0d visible pieces and %0d empty results",
			segs_taken, settings, pieces_seen, blanks_seen);
		$display("windows covered full field, inverted, line-shaped and edge-hugging cases");
		if (fail_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
